@@ rtl/tsoq_pkg.sv @@
package tsoq_pkg;

    localparam int STAMP_WIDTH = 32;
    localparam int DATA_WIDTH  = 32;
    localparam int TSOQ_DEPTH  = 16;

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_DRAIN = 2'd1,
        ACT_GET   = 2'd2,
        ACT_CLEAR = 2'd3
    } action_t;

    typedef struct packed {
        action_t                  action;
        logic [STAMP_WIDTH-1:0]   stamp;
        logic [DATA_WIDTH-1:0]    payload;
    } req_t;

    typedef struct packed {
        logic                     found;
        logic [DATA_WIDTH-1:0]    item_payload;
        logic [STAMP_WIDTH-1:0]   item_stamp;
        logic                     last;
        logic                     overflow;
    } rsp_t;

    typedef struct packed {
        logic [STAMP_WIDTH-1:0]   stamp;
        logic [DATA_WIDTH-1:0]    data;
    } entry_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_POP    = 2'd2
    } cell_op_t;

    typedef struct packed {
        cell_op_t                 op;
        logic                     tail_gt;
    } cell_cmd_t;

    typedef struct packed {
        logic                     move;
        logic                     gt;
        logic                     due;
    } cell_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_DRAIN = 2'd1,
        ST_GET   = 2'd2
    } state_t;

endpackage

@@ rtl/tsoq_cell.sv @@
module tsoq_cell
    import tsoq_pkg::*;
(
    input  logic                   clk,
    input  cell_cmd_t              cmd,
    input  logic [STAMP_WIDTH-1:0] key,
    input  entry_t                 new_entry,
    input  entry_t                 left_entry,
    input  entry_t                 right_entry,
    input  logic                   left_move,
    input  logic                   valid,
    input  logic                   at_tail,
    output entry_t                 entry,
    output cell_stat_t             stat
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   ge;
    logic   gt;
    logic   due;
    logic   move;
    logic   load;

    // Compare the held stamp against the broadcast key.
    assign ge   = (entry_reg.stamp >= key);
    assign gt   = (entry_reg.stamp > key);
    assign due  = valid && !gt;
    assign move = (cmd.op == CELL_INSERT) && valid && ge && cmd.tail_gt;
    assign stat = '{move: move, gt: gt, due: due};

    // Take the new entry at the first moving cell, or at the tail when nothing moves.
    assign load = !left_move && (move || at_tail);

    always_comb
    begin
        entry_next = entry_reg;
        unique case (cmd.op)
            CELL_INSERT:
            begin
                if (left_move)
                    entry_next = left_entry;
                else if (load)
                    entry_next = new_entry;
            end
            CELL_POP:
                entry_next = right_entry;
            default:
                entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

@@ rtl/timestamp_ordered_queue_top.sv @@
// Timestamp-ordered queue: up to DEPTH entries of (stamp, payload), kept sorted
// oldest first in a row of cells, one entry per cell. An add compares the new
// stamp against every cell at once and shifts the younger entries up by one in
// the same cycle; its single acknowledgement (overflow set when the store was
// full) appears in the output register the cycle after it is accepted. Clear
// likewise gives one acknowledgement. Drain and get pop from the oldest cell,
// the whole row shifting down one place per pop: a drain of n due entries
// gives n results, one per cycle while the consumer keeps rsp_ready high, and
// a get of n due entries gives one result, the newest of them. A drain or get
// with nothing due gives one not-found result. A new request is taken only
// between operations and while the output register is free or being read.
// Stored entries need no clearing after reset: only cells below the fill
// count are ever read.
module timestamp_ordered_queue_top
    import tsoq_pkg::*;
#(
    parameter int DEPTH = TSOQ_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int FILL_W = $clog2(DEPTH + 1);

    state_t              state_reg, state_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_t                rsp_reg, rsp_next;
    logic [STAMP_WIDTH-1:0] query_reg, query_next;
    entry_t              hold_reg, hold_next;
    logic                got_reg, got_next;

    cell_cmd_t           cmd;
    cell_op_t            cmd_op;
    logic [STAMP_WIDTH-1:0] key;
    entry_t              new_entry;
    entry_t              cell_entry [DEPTH];
    cell_stat_t          cell_stat  [DEPTH];
    logic [DEPTH-1:0]    cell_valid;
    logic [DEPTH-1:0]    cell_tail;
    logic [DEPTH-1:0]    gt_vec;

    logic out_free;
    logic accept;
    logic head_due;
    logic next_due;

    // The output register is free when empty or being read this cycle.
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == ST_IDLE) && out_free;
    assign accept    = req_valid && req_ready;

    // Broadcast the request stamp while idle, the held query otherwise.
    assign key       = (state_reg == ST_IDLE) ? req.stamp : query_reg;
    assign new_entry = '{stamp: req.stamp, data: req.payload};

    // Per-cell occupancy from the fill count.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            cell_valid[i] = (FILL_W'(i) < fill_reg);
            cell_tail[i]  = (FILL_W'(i) == fill_reg);
            gt_vec[i]     = cell_valid[i] && cell_stat[i].gt;
        end
    end

    // Entries are sorted, so any stored stamp above the key means the newest one is.
    assign cmd = '{op: cmd_op, tail_gt: |gt_vec};

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            entry_t left_e;
            entry_t right_e;
            logic   left_m;

            if (g == 0)
            begin : g_first
                assign left_e = new_entry;
                assign left_m = 1'b0;
            end
            else
            begin : g_inner
                assign left_e = cell_entry[g-1];
                assign left_m = cell_stat[g-1].move;
            end

            if (g == DEPTH - 1)
            begin : g_end
                assign right_e = cell_entry[g];
            end
            else
            begin : g_mid
                assign right_e = cell_entry[g+1];
            end

            tsoq_cell u_cell (
                .clk         (clk),
                .cmd         (cmd),
                .key         (key),
                .new_entry   (new_entry),
                .left_entry  (left_e),
                .right_entry (right_e),
                .left_move   (left_m),
                .valid       (cell_valid[g]),
                .at_tail     (cell_tail[g]),
                .entry       (cell_entry[g]),
                .stat        (cell_stat[g])
            );
        end
    endgenerate

    // Due entries form a prefix; the head and its neighbor tell whether to keep popping.
    assign head_due = cell_stat[0].due;
    assign next_due = cell_stat[1].due;

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        query_next     = query_reg;
        hold_next      = hold_reg;
        got_next       = got_reg;
        cmd_op         = CELL_HOLD;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.action)
                        ACT_ADD:
                        begin
                            rsp_valid_next = 1'b1;
                            rsp_next       = '{found: 1'b0, item_payload: '0,
                                               item_stamp: '0, last: 1'b1,
                                               overflow: 1'b0};
                            if (fill_reg == FILL_W'(DEPTH))
                                rsp_next.overflow = 1'b1;
                            else
                            begin
                                cmd_op    = CELL_INSERT;
                                fill_next = fill_reg + FILL_W'(1);
                            end
                        end
                        ACT_CLEAR:
                        begin
                            fill_next      = '0;
                            rsp_valid_next = 1'b1;
                            rsp_next       = '{found: 1'b0, item_payload: '0,
                                               item_stamp: '0, last: 1'b1,
                                               overflow: 1'b0};
                        end
                        ACT_DRAIN:
                        begin
                            query_next = req.stamp;
                            state_next = ST_DRAIN;
                        end
                        ACT_GET:
                        begin
                            query_next = req.stamp;
                            hold_next  = '0;
                            got_next   = 1'b0;
                            state_next = ST_GET;
                        end
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DRAIN:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    if (head_due)
                    begin
                        rsp_next = '{found: 1'b1, item_payload: cell_entry[0].data,
                                     item_stamp: cell_entry[0].stamp,
                                     last: !next_due, overflow: 1'b0};
                        cmd_op    = CELL_POP;
                        fill_next = fill_reg - FILL_W'(1);
                        if (!next_due)
                            state_next = ST_IDLE;
                    end
                    else
                    begin
                        // Nothing due at all: one not-found result.
                        rsp_next   = '{found: 1'b0, item_payload: '0,
                                       item_stamp: '0, last: 1'b1,
                                       overflow: 1'b0};
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_GET:
            begin
                if (head_due)
                begin
                    // Drop the head and keep it as the newest due so far.
                    cmd_op    = CELL_POP;
                    fill_next = fill_reg - FILL_W'(1);
                    hold_next = cell_entry[0];
                    got_next  = 1'b1;
                end
                else if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = '{found: got_reg, item_payload: hold_reg.data,
                                       item_stamp: hold_reg.stamp, last: 1'b1,
                                       overflow: 1'b0};
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg   <= rsp_next;
        query_reg <= query_next;
        hold_reg  <= hold_next;
        got_reg   <= got_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(DEPTH))
        else $error("fill count above depth");

    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg >= FILL_W'(2)) |-> (cell_entry[0].stamp <= cell_entry[1].stamp))
        else $error("oldest cells out of order");

    a_drain_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN && rsp_valid_next && out_free && rsp_next.last)
        |=> (state_reg == ST_IDLE))
        else $error("drain did not end on last result");

    a_ovf_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.overflow) |-> (!rsp_reg.found && rsp_reg.last))
        else $error("overflow result carries an entry");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == CELL_POP) |-> (fill_reg != '0))
        else $error("pop from empty store");

endmodule
